// ===== sv/srt_pkg.sv =====
package srt_pkg;

  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int SLOT_W = 4;
  localparam int PERM_W = 8;
  localparam int FLAG_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT     = 2'd0,
    CMD_FIND_ADDR  = 2'd1,
    CMD_FIND_FLAGS = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  typedef struct packed {
    logic lt_base;
    logic lt_limit;
    logic flag_hit;
  } cmp_res_t;

endpackage

// ===== sv/srt_ifs.sv =====
interface srt_in_if #(
  parameter int ADDR_BITS = 39
);
  logic                        valid;
  logic                        ready;
  logic [srt_pkg::CMD_W-1:0]   command;
  logic [ADDR_BITS-1:0]        start_addr;
  logic [ADDR_BITS:0]          end_addr;
  logic [srt_pkg::PERM_W-1:0]  perm_bits;
  logic [srt_pkg::FLAG_W-1:0]  flag_bits;
  logic [ADDR_BITS-1:0]        query_addr;

  modport source (
    output valid, command, start_addr, end_addr, perm_bits, flag_bits, query_addr,
    input  ready
  );
  modport sink (
    input  valid, command, start_addr, end_addr, perm_bits, flag_bits, query_addr,
    output ready
  );
endinterface

interface srt_out_if #(
  parameter int ADDR_BITS = 39
);
  logic                        valid;
  logic                        ready;
  logic [srt_pkg::STAT_W-1:0]  status;
  logic [srt_pkg::SLOT_W-1:0]  slot;
  logic [ADDR_BITS-1:0]        found_start;
  logic [ADDR_BITS:0]          found_end;
  logic [srt_pkg::PERM_W-1:0]  found_perm;
  logic [srt_pkg::FLAG_W-1:0]  found_flags;

  modport source (
    output valid, status, slot, found_start, found_end, found_perm, found_flags,
    input  ready
  );
  modport sink (
    input  valid, status, slot, found_start, found_end, found_perm, found_flags,
    output ready
  );
endinterface

// ===== sv/srt_ram.sv =====
module srt_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 119,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/srt_cmp.sv =====
module srt_cmp #(
  parameter int ADDR_BITS = 39
) (
  input  logic [ADDR_BITS-1:0]       key,
  input  logic [srt_pkg::FLAG_W-1:0] mask,
  input  logic [ADDR_BITS-1:0]       ent_base,
  input  logic [ADDR_BITS:0]         ent_limit,
  input  logic [srt_pkg::FLAG_W-1:0] ent_flags,
  output srt_pkg::cmp_res_t          res
);

  always_comb begin
    res.lt_base  = key < ent_base;
    res.lt_limit = {1'b0, key} < ent_limit;
    res.flag_hit = |(mask & ent_flags);
  end

endmodule

// ===== sv/srt_seq.sv =====
module srt_seq #(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 39,
  parameter int IDX_W       = 4,
  parameter int CNT_W       = 5,
  parameter int ENTRY_W     = 119
) (
  input  logic               clk,
  input  logic               rst_n,
  srt_in_if.sink             in_ch,
  srt_out_if.source          out_ch,
  output logic               ram_we,
  output logic [IDX_W-1:0]   ram_waddr,
  output logic [ENTRY_W-1:0] ram_wdata,
  output logic               ram_re,
  output logic [IDX_W-1:0]   ram_raddr,
  input  logic [ENTRY_W-1:0] ram_rdata
);

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_REGIONS);

  typedef struct packed {
    logic [ADDR_BITS-1:0]       base;
    logic [ADDR_BITS:0]         limit;
    logic [srt_pkg::PERM_W-1:0] perm;
    logic [srt_pkg::FLAG_W-1:0] flags;
  } entry_t;

  srt_pkg::state_t             state_r, state_nxt;
  srt_pkg::cmd_t               cmd_r, cmd_nxt;
  logic [ADDR_BITS-1:0]        key_r, key_nxt;
  entry_t                      new_r, new_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]            idx_r, idx_nxt;
  srt_pkg::status_t            res_status_r, res_status_nxt;
  logic [srt_pkg::SLOT_W-1:0]  res_slot_r, res_slot_nxt;
  entry_t                      res_ent_r, res_ent_nxt;
  logic                        out_valid_r, out_valid_nxt;
  srt_pkg::status_t            out_status_r;
  logic [srt_pkg::SLOT_W-1:0]  out_slot_r;
  entry_t                      out_ent_r;
  entry_t                      rd_ent;
  srt_pkg::cmp_res_t           cmp;
  logic                        in_fire;
  logic                        out_load;
  logic                        hit;

  assign rd_ent = entry_t'(ram_rdata);

  srt_cmp #(.ADDR_BITS(ADDR_BITS)) u_cmp (
    .key       (key_r),
    .mask      (new_r.flags),
    .ent_base  (rd_ent.base),
    .ent_limit (rd_ent.limit),
    .ent_flags (rd_ent.flags),
    .res       (cmp)
  );

  assign in_ch.ready = (state_r == srt_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == srt_pkg::S_DONE) && (!out_valid_r || out_ch.ready);
  assign hit = (cmd_r == srt_pkg::CMD_FIND_ADDR) ? (!cmp.lt_base && cmp.lt_limit)
                                                   : cmp.flag_hit;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    new_nxt        = new_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_ent_nxt    = res_ent_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[IDX_W-1:0];
    ram_wdata      = new_r;
    ram_re         = 1'b0;
    ram_raddr      = idx_r[IDX_W-1:0];
    unique case (state_r)
      srt_pkg::S_IDLE: begin
        if (in_fire) begin
          cmd_nxt        = srt_pkg::cmd_t'(in_ch.command);
          key_nxt        = (srt_pkg::cmd_t'(in_ch.command) == srt_pkg::CMD_FIND_ADDR)
                           ? in_ch.query_addr : in_ch.start_addr;
          new_nxt.base   = in_ch.start_addr;
          new_nxt.limit  = in_ch.end_addr;
          new_nxt.perm   = in_ch.perm_bits;
          new_nxt.flags  = in_ch.flag_bits;
          res_status_nxt = srt_pkg::ST_OK;
          res_slot_nxt   = '0;
          res_ent_nxt    = '0;
          unique case (srt_pkg::cmd_t'(in_ch.command))
            srt_pkg::CMD_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = srt_pkg::S_DONE;
            end
            srt_pkg::CMD_INSERT: begin
              if (cnt_r == FULL_CNT) begin
                res_status_nxt = srt_pkg::ST_FULL;
                state_nxt      = srt_pkg::S_DONE;
              end else begin
                idx_nxt   = cnt_r;
                state_nxt = srt_pkg::S_RD;
              end
            end
            default: begin
              idx_nxt   = '0;
              state_nxt = srt_pkg::S_RD;
            end
          endcase
        end
      end
      srt_pkg::S_RD: begin
        if (cmd_r == srt_pkg::CMD_INSERT) begin
          if (idx_r == '0) begin
            ram_we    = 1'b1;
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = srt_pkg::S_DONE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = IDX_W'(idx_r - 1'b1);
            state_nxt = srt_pkg::S_CMP;
          end
        end else begin
          if (idx_r == cnt_r) begin
            res_status_nxt = srt_pkg::ST_NOT_FOUND;
            state_nxt      = srt_pkg::S_DONE;
          end else begin
            ram_re    = 1'b1;
            state_nxt = srt_pkg::S_CMP;
          end
        end
      end
      srt_pkg::S_CMP: begin
        if (cmd_r == srt_pkg::CMD_INSERT) begin
          ram_we = 1'b1;
          if (cmp.lt_base) begin
            ram_wdata = ram_rdata;
            idx_nxt   = idx_r - 1'b1;
            state_nxt = srt_pkg::S_RD;
          end else begin
            res_slot_nxt = srt_pkg::SLOT_W'(idx_r);
            cnt_nxt      = cnt_r + 1'b1;
            state_nxt    = srt_pkg::S_DONE;
          end
        end else if (hit) begin
          res_slot_nxt = srt_pkg::SLOT_W'(idx_r);
          res_ent_nxt  = rd_ent;
          state_nxt    = srt_pkg::S_DONE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = srt_pkg::S_RD;
        end
      end
      srt_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = srt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = srt_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= srt_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    new_r        <= new_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_ent_r    <= res_ent_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_ent_r    <= res_ent_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot        = out_slot_r;
  assign out_ch.found_start = out_ent_r.base;
  assign out_ch.found_end   = out_ent_r.limit;
  assign out_ch.found_perm  = out_ent_r.perm;
  assign out_ch.found_flags = out_ent_r.flags;

endmodule

// ===== sv/sorted_region_table.sv =====
// Channel  Direction  Beat contents
// in_ch    sink       command, start_addr, end_addr, perm_bits, flag_bits, query_addr
// out_ch   source     status, slot, found_start, found_end, found_perm, found_flags
//
// One item at a time; a clear or a refused insert goes from S_IDLE straight to S_DONE,
// where its result waits until the result register is free. Insert and the finds scan
// the table memory, each entry read in S_RD and then compared in S_CMP.
// Reset empties the table; the entries themselves are not cleared.
// A result waiting on out_ch does not stop the next item from being taken and processed;
// only its hand-off to the result register waits.
module sorted_region_table #(
  parameter int MAX_REGIONS = 16,
  parameter int ADDR_BITS   = 39
) (
  input  logic      clk,
  input  logic      rst_n,
  srt_in_if.sink    in_ch,
  srt_out_if.source out_ch
);

  localparam int IDX_W   = $clog2(MAX_REGIONS);
  localparam int CNT_W   = $clog2(MAX_REGIONS + 1);
  localparam int ENTRY_W = ADDR_BITS + ADDR_BITS + 1 + srt_pkg::PERM_W + srt_pkg::FLAG_W;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  srt_ram #(
    .DEPTH (MAX_REGIONS),
    .WIDTH (ENTRY_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  srt_seq #(
    .MAX_REGIONS (MAX_REGIONS),
    .ADDR_BITS   (ADDR_BITS),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W),
    .ENTRY_W     (ENTRY_W)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("block took a second beat right after accepting one");

  a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("table memory read and written in the same cycle");

  a_read_then_compare: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |=> !in_ch.ready)
    else $error("table read issued without a following compare cycle");

endmodule
